/* design/tlag_pkg.sv */
// types, codes and constants shared by the access gate design
// no dependencies
`default_nettype none

package tlag_pkg;

   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned LEVEL_W  = 3;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned DELAY_W  = 14;
   localparam int unsigned SLOT_W   = 6;
   localparam int unsigned SYSNR_W  = 9;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WARNING   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEVATED  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EMERGENCY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AGING     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING  = 3'd5;

   // verdict codes
   localparam logic [1:0] VERDICT_ALLOW = 2'd0;
   localparam logic [1:0] VERDICT_DENY  = 2'd1;
   localparam logic [1:0] VERDICT_KILL  = 2'd2;
   localparam logic [1:0] VERDICT_TRACE = 2'd3;

   // alert levels
   localparam logic [LEVEL_W-1:0] LEVEL_EMERGENCY = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_CRITICAL  = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_ELEVATED  = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_WARNING   = 3'd4;
   localparam logic [LEVEL_W-1:0] LEVEL_NORMAL    = 3'd5;

   // dangerous operations
   localparam logic [SYSNR_W-1:0] SYSNR_DANGER_A = 9'd101;
   localparam logic [SYSNR_W-1:0] SYSNR_DANGER_B = 9'd165;
   localparam logic [SYSNR_W-1:0] SYSNR_DANGER_C = 9'd166;

   localparam logic [DELAY_W-1:0] DELAY_WARNING  = 14'd100;
   localparam logic [DELAY_W-1:0] DELAY_ELEVATED = 14'd1000;
   localparam logic [DELAY_W-1:0] DELAY_CRITICAL = 14'd10000;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [COUNT_W-1:0] warning;
      logic [COUNT_W-1:0] elevated;
      logic [COUNT_W-1:0] critical;
      logic [COUNT_W-1:0] emergency;
      logic [COUNT_W-1:0] aging;
      logic               learning;
   } csr_type;

   typedef struct packed {
      logic [SYSNR_W-1:0] syscall_number;
      logic               cache_hit;
      logic               cache_allowed;
      logic [TIME_W-1:0]  cache_expiry_sec;
      logic [TIME_W-1:0]  now_sec;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         verdict;
      logic [DELAY_W-1:0] throttle_us;
      logic [LEVEL_W-1:0] alert_level;
      logic               level_changed;
      logic               escalated;
      logic [COUNT_W-1:0] violation_total;
      logic               audit_issued;
      logic               audit_from_cache;
      logic               user_notified;
   } rsp_payload_type;

   // one table entry
   typedef struct packed {
      logic               used;
      logic [COUNT_W-1:0] count;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  last_change;
   } entry_type;

   function automatic logic [DELAY_W-1:0] delay_for(input logic [LEVEL_W-1:0] level);
      logic [DELAY_W-1:0] d;
      unique case (level)
         LEVEL_WARNING:  d = DELAY_WARNING;
         LEVEL_ELEVATED: d = DELAY_ELEVATED;
         LEVEL_CRITICAL: d = DELAY_CRITICAL;
         default:        d = '0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

/* design/tlag_req_if.sv */
// request channel of the access gate: valid, ready and the item fields
// no dependencies
`default_nettype none

interface tlag_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  task_slot;
   logic [8:0]  syscall_number;
   logic        cache_hit;
   logic        cache_allowed;
   logic [31:0] cache_expiry_sec;
   logic [31:0] now_sec;

   modport source (output valid, task_slot, syscall_number, cache_hit, cache_allowed,
                   cache_expiry_sec, now_sec, input ready);
   modport sink (input valid, task_slot, syscall_number, cache_hit, cache_allowed,
                 cache_expiry_sec, now_sec, output ready);
endinterface

`default_nettype wire

/* design/tlag_rsp_if.sv */
// response channel of the access gate: valid, ready and the result fields
// no dependencies
`default_nettype none

interface tlag_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  verdict;
   logic [13:0] throttle_us;
   logic [2:0]  alert_level;
   logic        level_changed;
   logic        escalated;
   logic [15:0] violation_total;
   logic        audit_issued;
   logic        audit_from_cache;
   logic        user_notified;

   modport source (output valid, verdict, throttle_us, alert_level, level_changed, escalated,
                   violation_total, audit_issued, audit_from_cache, user_notified,
                   input ready);
   modport sink (input valid, verdict, throttle_us, alert_level, level_changed, escalated,
                 violation_total, audit_issued, audit_from_cache, user_notified,
                 output ready);
endinterface

`default_nettype wire

/* design/tlag_ram.sv */
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module tlag_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/tlag_decide.sv */
// access decision and entry update for one item
// depends on tlag_pkg
`default_nettype none

module tlag_decide (
   input  tlag_pkg::req_payload_type item,
   input  tlag_pkg::entry_type       entry,
   input  tlag_pkg::csr_type         csr,
   output tlag_pkg::entry_type       entry_out,
   output tlag_pkg::rsp_payload_type rsp
);
   import tlag_pkg::*;

   entry_type          cur;
   logic               cache_valid;
   logic               dangerous;
   logic [TIME_W-1:0]  elapsed;
   logic               aged;
   logic [COUNT_W-1:0] cnt_inc;
   logic [COUNT_W-1:0] cnt_new;
   logic [LEVEL_W-1:0] recalc_level;

   // unused slot is created on first access
   always_comb begin
      if (entry.used) begin
         cur = entry;
      end else begin
         cur.used        = 1'b1;
         cur.count       = '0;
         cur.level       = LEVEL_NORMAL;
         cur.last_change = item.now_sec;
      end
   end

   assign cache_valid = item.cache_hit && (item.cache_expiry_sec != '0)
                        && (item.now_sec < item.cache_expiry_sec);
   assign dangerous = (item.syscall_number == SYSNR_DANGER_A)
                      || (item.syscall_number == SYSNR_DANGER_B)
                      || (item.syscall_number == SYSNR_DANGER_C);

   assign elapsed = item.now_sec - cur.last_change;
   assign aged    = elapsed > {{(TIME_W-COUNT_W){1'b0}}, csr.aging};
   assign cnt_inc = (cur.count == COUNT_MAX) ? cur.count : cur.count + 16'd1;
   assign cnt_new = aged ? (cnt_inc >> 1) : cnt_inc;

   always_comb begin
      priority if (cnt_new >= csr.emergency) begin
         recalc_level = LEVEL_EMERGENCY;
      end else if (cnt_new >= csr.critical) begin
         recalc_level = LEVEL_CRITICAL;
      end else if (cnt_new >= csr.elevated) begin
         recalc_level = LEVEL_ELEVATED;
      end else if (cnt_new >= csr.warning) begin
         recalc_level = LEVEL_WARNING;
      end else begin
         recalc_level = LEVEL_NORMAL;
      end
   end

   always_comb begin
      entry_out            = cur;
      rsp.verdict          = VERDICT_TRACE;
      rsp.throttle_us      = '0;
      rsp.level_changed    = 1'b0;
      rsp.escalated        = 1'b0;
      rsp.audit_issued     = 1'b0;
      rsp.audit_from_cache = 1'b0;
      rsp.user_notified    = 1'b0;
      priority if (cur.level == LEVEL_EMERGENCY) begin
         rsp.verdict       = VERDICT_KILL;
         rsp.audit_issued  = 1'b1;
         rsp.user_notified = 1'b1;
      end else if ((cur.level == LEVEL_CRITICAL) && !(cache_valid && item.cache_allowed)) begin
         rsp.verdict       = VERDICT_DENY;
         rsp.audit_issued  = 1'b1;
         rsp.user_notified = 1'b1;
      end else if ((cur.level == LEVEL_ELEVATED) && dangerous) begin
         rsp.verdict       = VERDICT_DENY;
         rsp.audit_issued  = 1'b1;
         rsp.user_notified = 1'b1;
      end else if (cache_valid && item.cache_allowed) begin
         rsp.verdict     = VERDICT_ALLOW;
         rsp.throttle_us = delay_for(cur.level);
      end else if (cache_valid) begin
         entry_out.count = cnt_new;
         if (recalc_level != cur.level) begin
            rsp.level_changed     = 1'b1;
            rsp.escalated         = recalc_level < cur.level;
            entry_out.level       = recalc_level;
            entry_out.last_change = item.now_sec;
         end
         rsp.verdict          = VERDICT_DENY;
         rsp.audit_issued     = 1'b1;
         rsp.audit_from_cache = 1'b1;
      end else begin
         rsp.verdict       = VERDICT_TRACE;
         rsp.user_notified = 1'b1;
         if (csr.learning) begin
            rsp.throttle_us = delay_for(cur.level);
         end
      end
      rsp.alert_level     = entry_out.level;
      rsp.violation_total = entry_out.count;
   end

endmodule

`default_nettype wire

/* design/threat_level_access_gate.sv */
// top level of the per-task alert level access gate
// depends on tlag_pkg, tlag_req_if, tlag_rsp_if, tlag_ram, tlag_decide
`default_nettype none

// The gate keeps one entry per task slot (used flag, violation count, level and
// time of last level change) in a single ram. An item is accepted, its slot entry
// is read in the next cycle, the decision is made and the entry written back in
// that same cycle, and the result is registered and then shown on the response
// channel. A new item is taken only once that write-back is done and the response
// register is empty or being read. After reset the table is cleared one slot a
// cycle, so no item is accepted until every slot is cleared; register writes are
// taken throughout. A task_slot beyond the table wraps modulo TASK_SLOTS.
module threat_level_access_gate #(
   parameter int unsigned TASK_SLOTS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tlag_req_if.sink                             req_bus,
   tlag_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_we,
   input  wire logic [tlag_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tlag_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tlag_pkg::*;

   localparam int unsigned IDX_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int unsigned SLOT_CODES = 2 ** SLOT_W;
   localparam int unsigned ENTRY_W   = $bits(entry_type);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   function automatic logic [SLOT_CODES*IDX_W-1:0] build_slot_map();
      logic [SLOT_CODES*IDX_W-1:0] m;
      m = '0;
      for (int i = 0; i < SLOT_CODES; i++) begin
         m[i*IDX_W +: IDX_W] = IDX_W'(i % TASK_SLOTS);
      end
      return m;
   endfunction

   localparam logic [SLOT_CODES*IDX_W-1:0] SLOT_MAP = build_slot_map();

   logic [1:0]      state_ff, state_in;
   logic [IDX_W-1:0] clear_idx_ff, clear_idx_in;
   logic [IDX_W-1:0] slot_ff;
   req_payload_type item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff;
   csr_type         csr_ff;

   logic            accept;
   logic [IDX_W-1:0] req_idx;
   entry_type       rd_entry;
   entry_type       new_entry;
   rsp_payload_type rsp_new;
   logic            wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept  = req_bus.valid && req_bus.ready;
   assign req_idx = SLOT_MAP[req_bus.task_slot*IDX_W +: IDX_W];

   always_comb begin
      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_idx_in = clear_idx_ff + 1'b1;
            if (clear_idx_ff == IDX_W'(TASK_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = (state_ff == ST_LOOKUP) ? 1'b1
                         : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         csr_ff.warning   <= 16'd3;
         csr_ff.elevated  <= 16'd6;
         csr_ff.critical  <= 16'd10;
         csr_ff.emergency <= 16'd15;
         csr_ff.aging     <= 16'd60;
         csr_ff.learning  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_WARNING:   csr_ff.warning   <= csr_wdata;
               CSR_ELEVATED:  csr_ff.elevated  <= csr_wdata;
               CSR_CRITICAL:  csr_ff.critical  <= csr_wdata;
               CSR_EMERGENCY: csr_ff.emergency <= csr_wdata;
               CSR_AGING:     csr_ff.aging     <= csr_wdata;
               CSR_LEARNING:  csr_ff.learning  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff                  <= req_idx;
         item_ff.syscall_number   <= req_bus.syscall_number;
         item_ff.cache_hit        <= req_bus.cache_hit;
         item_ff.cache_allowed    <= req_bus.cache_allowed;
         item_ff.cache_expiry_sec <= req_bus.cache_expiry_sec;
         item_ff.now_sec          <= req_bus.now_sec;
      end
      if (state_ff == ST_LOOKUP) begin
         rsp_ff <= rsp_new;
      end
   end

   assign wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_LOOKUP);
   assign wr_addr = (state_ff == ST_CLEAR) ? clear_idx_ff : slot_ff;
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : ENTRY_W'(new_entry);
   assign rd_entry = entry_type'(rd_data);

   tlag_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TASK_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (rd_data)
   );

   tlag_decide u_decide (
      .item      (item_ff),
      .entry     (rd_entry),
      .csr       (csr_ff),
      .entry_out (new_entry),
      .rsp       (rsp_new)
   );

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.verdict          = rsp_ff.verdict;
   assign rsp_bus.throttle_us      = rsp_ff.throttle_us;
   assign rsp_bus.alert_level      = rsp_ff.alert_level;
   assign rsp_bus.level_changed    = rsp_ff.level_changed;
   assign rsp_bus.escalated        = rsp_ff.escalated;
   assign rsp_bus.violation_total  = rsp_ff.violation_total;
   assign rsp_bus.audit_issued     = rsp_ff.audit_issued;
   assign rsp_bus.audit_from_cache = rsp_ff.audit_from_cache;
   assign rsp_bus.user_notified    = rsp_ff.user_notified;

endmodule

`default_nettype wire
